// ----- hdl/smpf_pkg.sv -----
package smpf_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_PATTERN_DEF   = 16;
    localparam int POSITION_BITS_DEF = 16;

    // Fixed field and register widths
    localparam int BYTE_W      = 8;
    localparam int PAT_BYTES   = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int LEN_W       = 5;
    localparam int OUT_W       = 16;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2
    } t_cfg_index;

    // Accent marker bytes, discounted from reported positions
    localparam logic [BYTE_W-1:0] MARK_A = 8'd161;
    localparam logic [BYTE_W-1:0] MARK_B = 8'd169;
    localparam logic [BYTE_W-1:0] MARK_C = 8'd173;
    localparam logic [BYTE_W-1:0] MARK_D = 8'd179;
    localparam logic [BYTE_W-1:0] MARK_E = 8'd186;
    localparam logic [BYTE_W-1:0] MARK_F = 8'd163;
    localparam logic [BYTE_W-1:0] MARK_G = 8'd167;

    // Per-cell control: en and clear are common to every cell, keep and tail differ per cell
    typedef struct packed {
        logic en;    // item accepted this cycle
        logic clear; // last byte of the text: drop all candidates
        logic keep;  // cell lies inside the current pattern length
        logic tail;  // cell is the final pattern position
    } t_cell_ctrl;

    function automatic logic is_marker(input logic [BYTE_W-1:0] b);
        return b inside {MARK_A, MARK_B, MARK_C, MARK_D, MARK_E, MARK_F, MARK_G};
    endfunction

endpackage

// ----- hdl/smpf_cell.sv -----
module smpf_cell #(
    parameter int POSITION_BITS = smpf_pkg::POSITION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  smpf_pkg::t_cell_ctrl     i_ctrl,
    input  logic                     i_prev_active,
    input  logic [POSITION_BITS-1:0] i_prev_start,
    input  logic                     i_byte_eq,
    output logic                     o_active,
    output logic [POSITION_BITS-1:0] o_start,
    output logic                     o_hit
);

    logic                     r_active;
    logic                     n_active;
    logic [POSITION_BITS-1:0] r_start;

    // candidate from the left neighbour extends by one byte
    assign o_hit    = i_prev_active & i_byte_eq;
    // the tail cell reports its hit and never holds it
    assign n_active = o_hit & i_ctrl.keep & ~i_ctrl.tail & ~i_ctrl.clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_ctrl.en) begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en && o_hit) begin
            r_start <= i_prev_start;
        end
    end

    assign o_active = r_active;
    assign o_start  = r_start;

endmodule

// ----- hdl/substring_match_position_finder.sv -----
// Streaming substring finder.
// Input channel (i_valid / o_ready): one text byte per item, with i_last_byte
// marking the final byte of a text. Output channel (o_valid / i_ready): a
// result item whenever a match of the configured pattern ends at a byte, and
// always for the last byte (o_text_done set, o_match_count = total).
// Config: write i_cfg_data to register i_cfg_index while i_cfg_we is high
// (0 pattern bytes 0..7, 1 pattern bytes 8..15, 2 pattern length).
// A result appears on the output register in the cycle after its byte is
// accepted. Throughput: one byte per cycle while the output is not stalled,
// since every partial match moves one cell along the chain per accepted byte.
// Stall: the output register holds its item; a new byte is still taken in
// the same cycle as the held item leaves, else o_ready drops while it waits.
// Reset clears the cell active flags, the counters and the output valid flag;
// pattern length resets to 1, the pattern bytes to zero. After a last byte the
// cells and counters return to zero, so no match spans two texts.
module substring_match_position_finder #(
    parameter int MAX_PATTERN   = smpf_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = smpf_pkg::POSITION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [smpf_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [smpf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input items
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [smpf_pkg::BYTE_W-1:0]         i_text_byte,
    input  logic                                i_last_byte,
    // result items
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_match_found,
    output logic [smpf_pkg::OUT_W-1:0]          o_match_start,
    output logic [smpf_pkg::OUT_W-1:0]          o_match_end,
    output logic [smpf_pkg::OUT_W-1:0]          o_match_count,
    output logic                                o_text_done
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PB    = POSITION_BITS;
    localparam int LW    = smpf_pkg::LEN_W;
    localparam int OW    = smpf_pkg::OUT_W;
    localparam logic [PB-1:0] POS_MAX = '1;

    // ---------------- configuration registers
    logic [smpf_pkg::CFG_DATA_W-1:0] r_pat_low;
    logic [smpf_pkg::CFG_DATA_W-1:0] r_pat_high;
    logic [LW-1:0]                   r_pat_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= LW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                smpf_pkg::CFG_PATTERN_LOW:    r_pat_low  <= i_cfg_data;
                smpf_pkg::CFG_PATTERN_HIGH:   r_pat_high <= i_cfg_data;
                smpf_pkg::CFG_PATTERN_LENGTH: r_pat_len  <= i_cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    logic [2*smpf_pkg::CFG_DATA_W-1:0] w_pat_all;
    assign w_pat_all = {r_pat_high, r_pat_low};

    // Effective length minus one: zero acts as one, oversize as MAX_PATTERN
    logic [LW-1:0]    w_len_m1;
    logic [IDX_W-1:0] w_sel;

    always_comb begin
        if (r_pat_len == '0) begin
            w_len_m1 = '0;
        end else if (r_pat_len > LW'(MAX_PATTERN)) begin
            w_len_m1 = LW'(MAX_PATTERN - 1);
        end else begin
            w_len_m1 = r_pat_len - LW'(1);
        end
    end
    assign w_sel = w_len_m1[IDX_W-1:0];

    // ---------------- handshake
    logic r_out_valid;
    logic w_in_acc;

    assign o_ready  = ~r_out_valid | i_ready;
    assign w_in_acc = i_valid & o_ready;

    // ---------------- text counters
    logic [PB-1:0] r_pos;
    logic [PB-1:0] r_mark;
    logic [PB-1:0] r_found_total;
    logic [PB-1:0] w_pos_next;
    logic [PB-1:0] w_mark_next;
    logic [PB-1:0] w_entry_start;

    assign w_pos_next  = (r_pos == POS_MAX) ? r_pos : r_pos + PB'(1);
    assign w_mark_next = (smpf_pkg::is_marker(i_text_byte) && r_mark != POS_MAX)
                         ? r_mark + PB'(1) : r_mark;
    // start already reduced by the markers seen so far
    assign w_entry_start = w_pos_next -
                           ((w_mark_next > w_pos_next) ? w_pos_next : w_mark_next);

    // ---------------- cell chain
    smpf_pkg::t_cell_ctrl w_ctrl   [MAX_PATTERN];
    logic                 w_prev_active [MAX_PATTERN];
    logic [PB-1:0]        w_prev_start  [MAX_PATTERN];
    logic                 w_active [MAX_PATTERN];
    logic [PB-1:0]        w_start  [MAX_PATTERN];
    logic                 w_hit    [MAX_PATTERN];
    logic                 w_eq     [MAX_PATTERN];

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        if (k == 0) begin : g_head
            // a new candidate may open at every byte
            assign w_prev_active[k] = 1'b1;
            assign w_prev_start[k]  = w_entry_start;
        end else begin : g_link
            assign w_prev_active[k] = w_active[k-1];
            assign w_prev_start[k]  = w_start[k-1];
        end

        assign w_eq[k]         = (i_text_byte == w_pat_all[8*k +: 8]);
        assign w_ctrl[k].en    = w_in_acc;
        assign w_ctrl[k].clear = i_last_byte;
        assign w_ctrl[k].keep  = (LW'(k) <= w_len_m1);
        assign w_ctrl[k].tail  = (LW'(k) == w_len_m1);

        smpf_cell #(
            .POSITION_BITS (POSITION_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl[k]),
            .i_prev_active (w_prev_active[k]),
            .i_prev_start  (w_prev_start[k]),
            .i_byte_eq     (w_eq[k]),
            .o_active      (w_active[k]),
            .o_start       (w_start[k]),
            .o_hit         (w_hit[k])
        );
    end

    // ---------------- match report
    logic          w_match;
    logic [PB-1:0] w_ms;
    logic [PB:0]   w_end_wide;
    logic [PB-1:0] w_me;
    logic [PB-1:0] w_found_next;
    logic          w_result;

    assign w_match      = w_hit[w_sel];
    assign w_ms         = w_prev_start[w_sel];
    assign w_end_wide   = {1'b0, w_ms} + (PB+1)'(w_len_m1);
    assign w_me         = (w_end_wide > {1'b0, POS_MAX}) ? POS_MAX : w_end_wide[PB-1:0];
    assign w_found_next = (w_match && r_found_total != POS_MAX)
                          ? r_found_total + PB'(1) : r_found_total;
    assign w_result     = w_match | i_last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_mark        <= '0;
            r_found_total <= '0;
        end else if (w_in_acc) begin
            if (i_last_byte) begin
                r_pos         <= '0;
                r_mark        <= '0;
                r_found_total <= '0;
            end else begin
                r_pos         <= w_pos_next;
                r_mark        <= w_mark_next;
                r_found_total <= w_found_next;
            end
        end
    end

    // ---------------- output register
    logic          r_found;
    logic [PB-1:0] r_ms;
    logic [PB-1:0] r_me;
    logic [PB-1:0] r_count;
    logic          r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= w_result;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_result) begin
            r_found <= w_match;
            r_ms    <= w_match ? w_ms : '0;
            r_me    <= w_match ? w_me : '0;
            r_count <= w_found_next;
            r_done  <= i_last_byte;
        end
    end

    // 16-bit views of the position-wide values
    logic [PB+OW-1:0] w_ms_ext;
    logic [PB+OW-1:0] w_me_ext;
    logic [PB+OW-1:0] w_cnt_ext;

    assign w_ms_ext  = {{OW{1'b0}}, r_ms};
    assign w_me_ext  = {{OW{1'b0}}, r_me};
    assign w_cnt_ext = {{OW{1'b0}}, r_count};

    assign o_valid       = r_out_valid;
    assign o_match_found = r_found;
    assign o_match_start = w_ms_ext[OW-1:0];
    assign o_match_end   = w_me_ext[OW-1:0];
    assign o_match_count = w_cnt_ext[OW-1:0];
    assign o_text_done   = r_done;

`ifndef NO_ASSERTIONS
    // a result without a match only comes from the last byte
    a_nomatch_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> (r_done && r_ms == '0 && r_me == '0))
        else $error("result without match is not an end-of-text item");

    // a last byte leaves the counters and chain head clear
    a_text_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_last_byte) |=> (r_pos == '0 && r_mark == '0 &&
                                       r_found_total == '0 && !w_active[0]))
        else $error("text state not cleared after last byte");

    // an empty output register never blocks input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_ready)
        else $error("input stalled with empty output register");

    // reported end never precedes start
    a_end_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_found) |-> (r_me >= r_ms))
        else $error("match end before match start");
`endif

endmodule
